>>> rtl/drkt_pkg.sv
// ----------------------------------------------------------------------------
// drkt_pkg
// Types and constants shared by the dual-range fusion trigger: payload
// structs, register indexes, status and phase codes, fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package drkt_pkg;

	typedef struct packed {
		logic        opcode;
		logic [14:0] echo_time_a;
		logic [14:0] echo_time_b;
	} drkt_in_t;

	typedef struct packed {
		logic        drive_on;
		logic [1:0]  phase;
		logic [12:0] estimate;
		logic [17:0] uncertainty;
		logic [12:0] spread;
		logic [3:0]  status;
		logic        no_reading;
	} drkt_out_t;

	localparam int CFG_W = 18;

	// register indexes
	localparam logic [2:0] CFG_MIN_DISTANCE    = 3'd0;
	localparam logic [2:0] CFG_MAX_DISTANCE    = 3'd1;
	localparam logic [2:0] CFG_SAFE_LIMIT      = 3'd2;
	localparam logic [2:0] CFG_PROCESS_NOISE   = 3'd3;
	localparam logic [2:0] CFG_STABLE_SPREAD   = 3'd4;
	localparam logic [2:0] CFG_CERTAINTY_LIMIT = 3'd5;
	localparam logic [2:0] CFG_ON_TIME_MS      = 3'd6;
	localparam logic [2:0] CFG_OFF_TIME_MS     = 3'd7;

	// status codes
	localparam logic [3:0] ST_ACTIVATED  = 4'd0;
	localparam logic [3:0] ST_ABOVE_SAFE = 4'd1;
	localparam logic [3:0] ST_HIST_BAD   = 4'd2;
	localparam logic [3:0] ST_UNSTABLE   = 4'd3;
	localparam logic [3:0] ST_UNCERTAIN  = 4'd4;
	localparam logic [3:0] ST_BUSY       = 4'd5;
	localparam logic [3:0] ST_BELOW_MIN  = 4'd6;
	localparam logic [3:0] ST_NO_SAFE    = 4'd7;
	localparam logic [3:0] ST_TICK       = 4'd8;

	// drive phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_ON   = 2'd1;
	localparam logic [1:0] PH_WAIT = 2'd2;

	localparam logic OP_SAMPLE = 1'b0;

	localparam int HISTORY_DEPTH_DEF = 5;

	// fixed-point constants
	localparam logic [14:0] ECHO_LIMIT   = 15'd25000;
	localparam logic [16:0] CM_PER_US    = 17'd281;     // 0.01715 cm/us in Q8.8 << 6
	localparam logic [16:0] BAND_LO      = 17'd4762;    // 18.6 cm
	localparam logic [16:0] BAND_HI      = 17'd5632;    // 22.0 cm
	localparam logic [13:0] BAND_OFFSET  = 14'd256;     // 1.0 cm
	localparam logic [12:0] DIST_SAT     = 13'd8191;
	localparam logic [13:0] DISAGREE     = 14'd256;     // 1.0 cm
	localparam logic [16:0] NOISE_UP     = 17'd68813;   // 1.05
	localparam logic [16:0] NOISE_DOWN   = 17'd62259;   // 0.95
	localparam logic [18:0] NOISE_MIN    = 19'd6554;    // 0.1
	localparam logic [18:0] NOISE_MAX    = 19'd131072;  // 2.0
	localparam logic [16:0] ONE_Q16      = 17'd65536;
	localparam logic [34:0] ROUND_HALF   = 35'd32768;
	localparam logic [17:0] VAR_SAT      = 18'h3FFFF;
	localparam logic [15:0] ELAPSED_SAT  = 16'hFFFF;

	localparam logic [12:0] RST_MIN_DISTANCE    = 13'd512;
	localparam logic [12:0] RST_MAX_DISTANCE    = 13'd5120;
	localparam logic [12:0] RST_SAFE_LIMIT      = 13'd4736;
	localparam logic [15:0] RST_PROCESS_NOISE   = 16'd655;
	localparam logic [12:0] RST_STABLE_SPREAD   = 13'd51;
	localparam logic [17:0] RST_CERTAINTY_LIMIT = 18'd19661;
	localparam logic [15:0] RST_ON_TIME_MS      = 16'd5000;
	localparam logic [15:0] RST_OFF_TIME_MS     = 16'd1000;
	localparam logic [12:0] RST_ESTIMATE        = 13'd2560;
	localparam logic [17:0] RST_VARIANCE        = 18'd65536;
	localparam logic [17:0] RST_NOISE           = 18'd32768;

endpackage

`default_nettype wire

>>> rtl/dual_range_kalman_trigger.sv
// ----------------------------------------------------------------------------
// dual_range_kalman_trigger
// Two-echo distance fusion through a scalar Kalman filter with adaptive
// measurement noise, an estimate history with spread check, and an
// on / wait-off activation timer advanced by millisecond ticks.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  in        sink       in_valid / in_stall       drkt_in_t  (opcode, two echo times)
//  out       source     out_valid / out_stall     drkt_out_t (one result per item)
//  cfg       sink       cfg_write                 cfg_index, cfg_data
//
//  a sample item runs, for each valid echo, a 17-step restoring division
//  for the gain plus four multiply steps, all on one shared 18x17
//  multiplier and one subtractor
//  the history scan reads one filled entry per cycle (up to HISTORY_DEPTH)
//  in_stall is high from the transfer in until the result is loaded
//  a result waiting on out_stall holds the sequencer in its last step only;
//  the next item is taken as soon as the result sits in the output register
//  reset clears all filter state, history and timer at once
// ----------------------------------------------------------------------------
`default_nettype none

module dual_range_kalman_trigger #(
	parameter int HISTORY_DEPTH = drkt_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output      logic                     in_stall,
	input  wire drkt_pkg::drkt_in_t       in_data,
	output      logic                     out_valid,
	input  wire logic                     out_stall,
	output      drkt_pkg::drkt_out_t      out_data,
	input  wire logic                     cfg_write,
	input  wire logic [2:0]               cfg_index,
	input  wire logic [drkt_pkg::CFG_W-1:0] cfg_data
);
	import drkt_pkg::*;

	localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam logic [IW-1:0] PTR_LAST = IW'(HISTORY_DEPTH - 1);
	localparam logic [CW-1:0] FILL_MAX = CW'(HISTORY_DEPTH);

	typedef enum logic [14:0] {
		S_IDLE  = 15'b000000000000001,
		S_MULD  = 15'b000000000000010,
		S_DIST  = 15'b000000000000100,
		S_DIVI  = 15'b000000000001000,
		S_DIV   = 15'b000000000010000,
		S_MAGM  = 15'b000000000100000,
		S_MAGA  = 15'b000000001000000,
		S_PM    = 15'b000000010000000,
		S_PA    = 15'b000000100000000,
		S_RM    = 15'b000001000000000,
		S_RA    = 15'b000010000000000,
		S_CLAMP = 15'b000100000000000,
		S_SCAN  = 15'b001000000000000,
		S_DEC   = 15'b010000000000000,
		S_OUT   = 15'b100000000000000
	} state_t;

	// configuration registers
	logic [12:0] min_q, max_q, safe_q, stable_q;
	logic [15:0] pnoise_q, on_ms_q, off_ms_q;
	logic [17:0] cert_q;

	// filter and timer state
	state_t      state_q;
	logic [12:0] x_q;
	logic [17:0] p_q, na_q, nb_q;
	logic [12:0] hist_q [HISTORY_DEPTH];
	logic [IW-1:0] ptr_q, idx_q;
	logic [CW-1:0] filled_q;
	logic [1:0]  phase_q;
	logic [15:0] elapsed_q;
	logic [12:0] spread_q, lo_q, hi_q;
	logic        bad_q;

	// per-item working registers
	logic [14:0] ta_q, tb_q;
	logic [12:0] za_q, zb_q;
	logic        va_q, vb_q, sel_q;
	logic [18:0] den_q;
	logic [19:0] rem_q;
	logic [16:0] k_q;
	logic [4:0]  cnt_q;
	logic [3:0]  status_q;
	logic        noread_q;
	logic [34:0] prod_q;

	logic        out_valid_q;
	drkt_out_t   out_q;

	function automatic logic [12:0] clamp_dist(input logic [16:0] v,
	                                           input logic [12:0] lo,
	                                           input logic [12:0] hi);
		if (v < {4'd0, lo})
			return lo;
		else if (v > {4'd0, hi})
			return hi;
		else
			return v[12:0];
	endfunction

	// shared multiplier operands
	logic [17:0] mul_a;
	logic [16:0] mul_b;
	logic [12:0] z_sel, abs_diff;
	logic [17:0] r_sel;
	logic        diff_neg;
	logic [34:0] rnd_sum;
	logic [16:0] dist_v;
	logic [14:0] t_sel;
	logic        t_ok;
	logic [12:0] dist_z;
	logic [13:0] band_f;
	logic [13:0] dz;
	logic [18:0] adapt_v;
	logic [17:0] adapt_c;
	logic [19:0] trial;
	logic        trial_ge;
	logic [12:0] hist_e, lo_n, hi_n;
	logic [17:0] p_pred;
	logic [18:0] p_sum;
	logic        in_xfer, out_load;
	logic [1:0]  phase_n;
	logic [15:0] elapsed_n;
	logic        activate_ok, safe_hit;

	always_comb begin
		z_sel    = sel_q ? zb_q : za_q;
		r_sel    = sel_q ? nb_q : na_q;
		t_sel    = sel_q ? tb_q : ta_q;
		diff_neg = z_sel < x_q;
		abs_diff = diff_neg ? (x_q - z_sel) : (z_sel - x_q);
		dz       = (za_q >= zb_q) ? {1'b0, za_q - zb_q} : {1'b0, zb_q - za_q};
		unique case (1'b1)
			state_q[4'd5]: begin  // magnitude step
				mul_a = {5'd0, abs_diff};
				mul_b = k_q;
			end
			state_q[4'd7]: begin  // variance update step
				mul_a = p_q;
				mul_b = ONE_Q16 - k_q;
			end
			state_q[4'd9]: begin  // noise adapt step
				mul_a = r_sel;
				mul_b = (dz > DISAGREE) ? NOISE_UP : NOISE_DOWN;
			end
			default: begin  // echo time to distance
				mul_a = {3'd0, t_sel};
				mul_b = CM_PER_US;
			end
		endcase
	end

	always_comb begin
		rnd_sum = prod_q + ROUND_HALF;
		dist_v  = prod_q[22:6];
		t_ok    = (t_sel != 15'd0) && (t_sel < ECHO_LIMIT);
		band_f  = {1'b0, max_q} + BAND_OFFSET;
		if (dist_v >= BAND_LO && dist_v < BAND_HI)
			dist_z = band_f[13] ? DIST_SAT : band_f[12:0];
		else
			dist_z = clamp_dist(dist_v, min_q, max_q);
		adapt_v = rnd_sum[34:16];
		if (adapt_v < NOISE_MIN)
			adapt_c = NOISE_MIN[17:0];
		else if (adapt_v > NOISE_MAX)
			adapt_c = NOISE_MAX[17:0];
		else
			adapt_c = adapt_v[17:0];
		trial    = (cnt_q == 5'd0) ? rem_q : {rem_q[18:0], 1'b0};
		trial_ge = trial >= {1'b0, den_q};
		hist_e   = hist_q[idx_q];
		lo_n     = (hist_e < lo_q) ? hist_e : lo_q;
		hi_n     = (hist_e > hi_q) ? hist_e : hi_q;
		p_sum    = {1'b0, p_q} + {3'd0, pnoise_q};
		p_pred   = p_sum[18] ? VAR_SAT : p_sum[17:0];
		activate_ok = (x_q >= min_q) && (x_q <= safe_q) && !bad_q
			&& (spread_q < stable_q) && (p_q < cert_q) && (phase_q == PH_IDLE);
		safe_hit = (va_q && za_q <= safe_q) || (vb_q && zb_q <= safe_q);
	end

	// timer rule applied after every item
	always_comb begin
		phase_n   = phase_q;
		elapsed_n = elapsed_q;
		if (phase_q == PH_ON && elapsed_q >= on_ms_q) begin
			phase_n   = PH_WAIT;
			elapsed_n = 16'd0;
		end else if (phase_q == PH_WAIT && elapsed_q >= off_ms_q) begin
			phase_n = PH_IDLE;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// shared multiplier, product registered every cycle
	always_ff @(posedge clk) begin
		prod_q <= 35'(mul_a * mul_b);
	end

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q    <= RST_MIN_DISTANCE;
			max_q    <= RST_MAX_DISTANCE;
			safe_q   <= RST_SAFE_LIMIT;
			pnoise_q <= RST_PROCESS_NOISE;
			stable_q <= RST_STABLE_SPREAD;
			cert_q   <= RST_CERTAINTY_LIMIT;
			on_ms_q  <= RST_ON_TIME_MS;
			off_ms_q <= RST_OFF_TIME_MS;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_MIN_DISTANCE:    min_q    <= cfg_data[12:0];
				CFG_MAX_DISTANCE:    max_q    <= cfg_data[12:0];
				CFG_SAFE_LIMIT:      safe_q   <= cfg_data[12:0];
				CFG_PROCESS_NOISE:   pnoise_q <= cfg_data[15:0];
				CFG_STABLE_SPREAD:   stable_q <= cfg_data[12:0];
				CFG_CERTAINTY_LIMIT: cert_q   <= cfg_data[17:0];
				CFG_ON_TIME_MS:      on_ms_q  <= cfg_data[15:0];
				CFG_OFF_TIME_MS:     off_ms_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// working registers without reset
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ta_q <= in_data.echo_time_a;
			tb_q <= in_data.echo_time_b;
		end
		if (state_q == S_DIVI) begin
			den_q <= {1'b0, p_q} + {1'b0, r_sel};
			rem_q <= {2'd0, p_q};
			k_q   <= 17'd0;
		end
		if (state_q == S_DIV) begin
			rem_q <= trial_ge ? (trial - {1'b0, den_q}) : trial;
			if (cnt_q == 5'd16 && den_q == 19'd0)
				k_q <= 17'd0;  // zero noise and variance: no gain
			else
				k_q <= {k_q[15:0], trial_ge};
		end
		if (state_q == S_DIST) begin
			if (sel_q)
				zb_q <= dist_z;
			else
				za_q <= dist_z;
		end
		if (out_load) begin
			out_q.drive_on    <= (phase_n == PH_ON);
			out_q.phase       <= phase_n;
			out_q.estimate    <= x_q;
			out_q.uncertainty <= p_q;
			out_q.spread      <= spread_q;
			out_q.status      <= status_q;
			out_q.no_reading  <= noread_q;
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			x_q         <= RST_ESTIMATE;
			p_q         <= RST_VARIANCE;
			na_q        <= RST_NOISE;
			nb_q        <= RST_NOISE;
			for (int i = 0; i < HISTORY_DEPTH; i++)
				hist_q[i] <= 13'd0;
			ptr_q       <= '0;
			idx_q       <= '0;
			filled_q    <= '0;
			phase_q     <= PH_IDLE;
			elapsed_q   <= 16'd0;
			spread_q    <= 13'd0;
			lo_q        <= 13'd0;
			hi_q        <= 13'd0;
			bad_q       <= 1'b0;
			va_q        <= 1'b0;
			vb_q        <= 1'b0;
			sel_q       <= 1'b0;
			cnt_q       <= 5'd0;
			status_q    <= ST_TICK;
			noread_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (in_data.opcode == OP_SAMPLE) begin
							p_q     <= p_pred;
							sel_q   <= 1'b0;
							state_q <= S_MULD;
						end else begin
							if (elapsed_q != ELAPSED_SAT)
								elapsed_q <= elapsed_q + 16'd1;
							status_q <= ST_TICK;
							noread_q <= 1'b0;
							state_q  <= S_OUT;
						end
					end
				end
				S_MULD: state_q <= S_DIST;
				S_DIST: begin
					if (sel_q) begin
						vb_q <= t_ok;
						// corrections start with echo a if it is valid
						sel_q   <= !va_q;
						state_q <= (va_q || t_ok) ? S_DIVI : S_CLAMP;
					end else begin
						va_q    <= t_ok;
						sel_q   <= 1'b1;
						state_q <= S_MULD;
					end
				end
				S_DIVI: begin
					cnt_q   <= 5'd0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16)
						state_q <= S_MAGM;
				end
				S_MAGM: state_q <= S_MAGA;
				S_MAGA: begin
					x_q     <= diff_neg ? (x_q - rnd_sum[28:16]) : (x_q + rnd_sum[28:16]);
					state_q <= S_PM;
				end
				S_PM: state_q <= S_PA;
				S_PA: begin
					p_q <= rnd_sum[33:16];
					if (!sel_q && vb_q) begin
						sel_q   <= 1'b1;
						state_q <= S_DIVI;
					end else if (va_q && vb_q) begin
						sel_q   <= 1'b0;
						state_q <= S_RM;
					end else begin
						state_q <= S_CLAMP;
					end
				end
				S_RM: state_q <= S_RA;
				S_RA: begin
					if (sel_q) begin
						nb_q    <= adapt_c;
						state_q <= S_CLAMP;
					end else begin
						na_q    <= adapt_c;
						sel_q   <= 1'b1;
						state_q <= S_RM;
					end
				end
				S_CLAMP: begin
					x_q           <= clamp_dist({4'd0, x_q}, min_q, max_q);
					hist_q[ptr_q] <= clamp_dist({4'd0, x_q}, min_q, max_q);
					ptr_q         <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
					if (filled_q < FILL_MAX)
						filled_q <= filled_q + 1'b1;
					idx_q    <= '0;
					lo_q     <= DIST_SAT;
					hi_q     <= 13'd0;
					bad_q    <= 1'b0;
					noread_q <= !va_q && !vb_q;
					state_q  <= S_SCAN;
				end
				S_SCAN: begin
					lo_q  <= lo_n;
					hi_q  <= hi_n;
					if (hist_e > safe_q)
						bad_q <= 1'b1;
					idx_q <= idx_q + 1'b1;
					if (CW'(idx_q) + 1'b1 == filled_q) begin
						spread_q <= hi_n - lo_n;
						state_q  <= S_DEC;
					end
				end
				S_DEC: begin
					priority if (activate_ok) begin
						if (safe_hit) begin
							phase_q   <= PH_ON;
							elapsed_q <= 16'd0;
							status_q  <= ST_ACTIVATED;
						end else begin
							status_q <= ST_NO_SAFE;
						end
					end else if (x_q > safe_q)
						status_q <= ST_ABOVE_SAFE;
					else if (bad_q)
						status_q <= ST_HIST_BAD;
					else if (!(spread_q < stable_q))
						status_q <= ST_UNSTABLE;
					else if (!(p_q < cert_q))
						status_q <= ST_UNCERTAIN;
					else if (phase_q != PH_IDLE)
						status_q <= ST_BUSY;
					else
						status_q <= ST_BELOW_MIN;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						phase_q   <= phase_n;
						elapsed_q <= elapsed_n;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");
	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("unused drive phase code reached");
	a_noise_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, na_q} >= NOISE_MIN && {1'b0, na_q} <= NOISE_MAX
		&& {1'b0, nb_q} >= NOISE_MIN && {1'b0, nb_q} <= NOISE_MAX)
		else $error("measurement noise left its clamp range");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= FILL_MAX)
		else $error("history fill count beyond depth");
	a_load_clears_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid && !in_stall)
		else $error("result load did not free the input");
`endif

endmodule

`default_nettype wire

>>> verif/tb_dual_range_kalman_trigger.sv
// ----------------------------------------------------------------------------
// tb_dual_range_kalman_trigger
// Self-checking bench for the dual-range fusion trigger: a queue-fed driver,
// a clocked monitor and a behavioral predictor of filter, history and timer.
// Results are compared as whole structs, in order, across several settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dual_range_kalman_trigger;
	import drkt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HDEPTH = 5;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	drkt_in_t in_data;
	logic out_valid;
	logic out_stall;
	drkt_out_t out_data;
	logic cfg_write;
	logic [2:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	dual_range_kalman_trigger dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of the registers
	int unsigned min_d, max_d, safe_d, proc_noise, spread_lim, cert_lim, on_ms, off_ms;
	// predictor copy of the filter state
	int pos_est;
	int unsigned est_var, nz_a, nz_b, hist_fill, hist_ptr, drv_phase, elapsed;
	int unsigned hist [HDEPTH];

	drkt_in_t pending_items[$];
	drkt_out_t expected_results[$];
	int errors = 0;
	int results_seen = 0;
	bit idle_free = 0;     // last part of run: no random idling
	bit in_taken = 0;      // offered item already transferred
	int long_hold = 0;     // receiver hold-off length, counted down by the receiver stall process
	int send_gap = 0;
	int recv_gap = 0;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic int clamp_dist(int v);
		if (v < int'(min_d)) return min_d;
		if (v > int'(max_d)) return max_d;
		return v;
	endfunction

	// echo time to distance; returns 0 for an invalid echo
	function automatic bit echo_dist(int unsigned t, output int d);
		int unsigned v;
		longint unsigned f;
		d = 0;
		if (t == 0 || t >= 25000) return 0;
		v = (t * 281) >> 6;
		if (v >= 4762 && v < 5632) begin
			f = max_d + 256;
			d = (f > 8191) ? 8191 : int'(f);
		end else begin
			d = clamp_dist(int'(v));
		end
		return 1;
	endfunction

	task automatic kalman_correct(int z, int unsigned r);
		longint unsigned p, den, k, mag;
		longint diff, adiff;
		p = est_var;
		den = p + r;
		k = (den != 0) ? (p << 16) / den : 0;
		diff = z - pos_est;
		adiff = (diff < 0) ? -diff : diff;
		mag = (longint'(adiff) * k + 32768) >> 16;
		pos_est = (diff < 0) ? pos_est - int'(mag) : pos_est + int'(mag);
		est_var = int'((p * (65536 - k) + 32768) >> 16);
	endtask

	function automatic int unsigned adapt_noise(int unsigned r, int unsigned mul);
		longint unsigned v;
		v = (longint'(r) * mul + 32768) >> 16;
		if (v < 6554) return 6554;
		if (v > 131072) return 131072;
		return int'(v);
	endfunction

	function automatic int unsigned hist_spread();
		int unsigned lo, hi;
		if (hist_fill == 0) return 0;
		lo = hist[0];
		hi = hist[0];
		for (int i = 1; i < hist_fill; i++) begin
			if (hist[i] > hi) hi = hist[i];
			if (hist[i] < lo) lo = hist[i];
		end
		return hi - lo;
	endfunction

	task automatic predict_reset();
		min_d = RST_MIN_DISTANCE; max_d = RST_MAX_DISTANCE; safe_d = RST_SAFE_LIMIT;
		proc_noise = RST_PROCESS_NOISE; spread_lim = RST_STABLE_SPREAD;
		cert_lim = RST_CERTAINTY_LIMIT; on_ms = RST_ON_TIME_MS; off_ms = RST_OFF_TIME_MS;
		pos_est = RST_ESTIMATE; est_var = RST_VARIANCE;
		nz_a = RST_NOISE; nz_b = RST_NOISE;
		foreach (hist[i]) hist[i] = 0;
		hist_fill = 0; hist_ptr = 0; drv_phase = PH_IDLE; elapsed = 0;
	endtask

	task automatic predict_item(drkt_in_t it);
		drkt_out_t r;
		logic [3:0] st;
		bit no_rd, va, vb, all_ok;
		int za, zb, d;
		int unsigned v, sp, mul;
		st = ST_TICK;
		no_rd = 0;
		if (it.opcode == OP_SAMPLE) begin
			va = echo_dist(it.echo_time_a, za);
			vb = echo_dist(it.echo_time_b, zb);
			v = est_var + proc_noise;
			est_var = (v > 262143) ? 262143 : v;
			if (va) kalman_correct(za, nz_a);
			if (vb) kalman_correct(zb, nz_b);
			if (va && vb) begin
				d = za - zb;
				mul = (d > 256 || d < -256) ? 68813 : 62259;
				nz_a = adapt_noise(nz_a, mul);
				nz_b = adapt_noise(nz_b, mul);
			end
			pos_est = clamp_dist(pos_est);
			hist[hist_ptr] = pos_est;
			hist_ptr = (hist_ptr + 1) % HDEPTH;
			if (hist_fill < HDEPTH) hist_fill++;
			sp = hist_spread();
			all_ok = 1;
			foreach (hist[i]) if (hist[i] > safe_d) all_ok = 0;
			if (pos_est >= int'(min_d) && pos_est <= int'(safe_d) && all_ok
				&& sp < spread_lim && est_var < cert_lim && drv_phase == PH_IDLE) begin
				if ((va && za <= int'(safe_d)) || (vb && zb <= int'(safe_d))) begin
					drv_phase = PH_ON; elapsed = 0; st = ST_ACTIVATED;
				end else begin
					st = ST_NO_SAFE;
				end
			end else if (pos_est > int'(safe_d)) st = ST_ABOVE_SAFE;
			else if (!all_ok) st = ST_HIST_BAD;
			else if (!(sp < spread_lim)) st = ST_UNSTABLE;
			else if (!(est_var < cert_lim)) st = ST_UNCERTAIN;
			else if (drv_phase != PH_IDLE) st = ST_BUSY;
			else st = ST_BELOW_MIN;
			no_rd = !va && !vb;
		end else if (elapsed < 65535) begin
			elapsed++;
		end
		if (drv_phase == PH_ON && elapsed >= on_ms) begin
			drv_phase = PH_WAIT; elapsed = 0;
		end else if (drv_phase == PH_WAIT && elapsed >= off_ms) begin
			drv_phase = PH_IDLE;
		end
		r.drive_on = (drv_phase == PH_ON);
		r.phase = drv_phase[1:0];
		r.estimate = pos_est[12:0];
		r.uncertainty = est_var[17:0];
		r.spread = 13'(hist_spread());
		r.status = st;
		r.no_reading = no_rd;
		expected_results.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// driver: payload held until transferred, new item at the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				in_taken = 1'b0;
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0 && !idle_free && $urandom_range(0, 7) == 0) begin
					send_gap <= $urandom_range(1, 5) - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					in_data <= pending_items[0];
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// transfer in: predict and retire from the pending queue
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			predict_item(in_data);
			void'(pending_items.pop_front());
			in_taken = 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// monitor and receiver stall
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		drkt_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %p", $time, out_data);
			end else begin
				want = expected_results.pop_front();
				if (out_data !== want) begin
					errors++;
					$display("%0t: mismatch expected %p actual %p", $time, want, out_data);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (long_hold > 0) begin
				long_hold <= long_hold - 1;
				out_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_stall <= 1'b1;
			end else if (!idle_free && $urandom_range(0, 7) == 0) begin
				recv_gap <= $urandom_range(1, 5) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	task automatic wait_drained();
		while (pending_items.size() > 0 || expected_results.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, int unsigned val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_MIN_DISTANCE:    min_d = val & 8191;
			CFG_MAX_DISTANCE:    max_d = val & 8191;
			CFG_SAFE_LIMIT:      safe_d = val & 8191;
			CFG_PROCESS_NOISE:   proc_noise = val & 65535;
			CFG_STABLE_SPREAD:   spread_lim = val & 8191;
			CFG_CERTAINTY_LIMIT: cert_lim = val & 262143;
			CFG_ON_TIME_MS:      on_ms = val & 65535;
			default:             off_ms = val & 65535;
		endcase
	endtask

	function automatic drkt_in_t sample_item(int unsigned a, int unsigned b);
		drkt_in_t it;
		it.opcode = OP_SAMPLE;
		it.echo_time_a = a[14:0];
		it.echo_time_b = b[14:0];
		return it;
	endfunction

	function automatic drkt_in_t tick_item();
		drkt_in_t it;
		it.opcode = ~OP_SAMPLE;
		it.echo_time_a = 15'($urandom);
		it.echo_time_b = 15'($urandom);
		return it;
	endfunction

	// echo time biased toward the useful range, with some invalid or full-range values
	function automatic int unsigned rand_echo(int unsigned centre);
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(0, 32767);
			2: return $urandom_range(25000, 32767);
			default: return centre + $urandom_range(0, 6) - 3;
		endcase
	endfunction

	// random sequence: samples around a target that moves now and then, mixed with ticks at tick_pct percent
	task automatic queue_random(int count, int unsigned tick_pct);
		int unsigned centre;
		centre = $urandom_range(40, 500);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 39) == 0) centre = $urandom_range(10, 1200);
			if ($urandom_range(0, 99) < tick_pct)
				pending_items.push_back(tick_item());
			else
				pending_items.push_back(sample_item(rand_echo(centre), rand_echo(centre)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_MIN_DISTANCE;
		cfg_data = '0;
		predict_reset();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, invalid echoes, diffuse band, clamps, ticks
		pending_items.push_back(sample_item(0, 0));
		pending_items.push_back(sample_item(32767, 24999));
		pending_items.push_back(sample_item(25000, 1));
		pending_items.push_back(sample_item(1085, 1100));   // diffuse band
		pending_items.push_back(sample_item(3, 20000));     // below min / above max
		pending_items.push_back(sample_item(600, 100));     // sensors disagree
		for (int i = 0; i < 10; i++) pending_items.push_back(sample_item(300, 301));
		pending_items.push_back(tick_item());
		pending_items.push_back(sample_item(21845, 10922)); // alternating bit patterns
		pending_items.push_back(sample_item(10922, 21845));
		wait_drained();

		// short timers, loose limits so activation cycles quickly
		write_reg(CFG_ON_TIME_MS, 3);
		write_reg(CFG_OFF_TIME_MS, 2);
		write_reg(CFG_STABLE_SPREAD, 400);
		write_reg(CFG_CERTAINTY_LIMIT, 40000);
		queue_random(350, 35);
		// receiver holds off while the sender keeps offering
		long_hold = 200;
		wait_drained();

		// extremes of the distance and noise registers
		write_reg(CFG_MIN_DISTANCE, 0);
		write_reg(CFG_MAX_DISTANCE, 8191);
		write_reg(CFG_SAFE_LIMIT, 8191);
		write_reg(CFG_PROCESS_NOISE, 0);
		write_reg(CFG_STABLE_SPREAD, 8191);
		write_reg(CFG_CERTAINTY_LIMIT, 262143);
		write_reg(CFG_ON_TIME_MS, 1);
		write_reg(CFG_OFF_TIME_MS, 1);
		queue_random(350, 25);
		wait_drained();

		write_reg(CFG_PROCESS_NOISE, 65535);
		write_reg(CFG_MIN_DISTANCE, 8191);
		write_reg(CFG_MAX_DISTANCE, 0);
		write_reg(CFG_SAFE_LIMIT, 0);
		write_reg(CFG_CERTAINTY_LIMIT, 0);
		write_reg(CFG_STABLE_SPREAD, 0);
		write_reg(CFG_ON_TIME_MS, 65535);
		write_reg(CFG_OFF_TIME_MS, 65535);
		queue_random(250, 30);
		wait_drained();

		// back to typical values with moderate timers
		write_reg(CFG_MIN_DISTANCE, 512);
		write_reg(CFG_MAX_DISTANCE, 5120);
		write_reg(CFG_SAFE_LIMIT, 4736);
		write_reg(CFG_PROCESS_NOISE, 100);
		write_reg(CFG_STABLE_SPREAD, 120);
		write_reg(CFG_CERTAINTY_LIMIT, 30000);
		write_reg(CFG_ON_TIME_MS, 20);
		write_reg(CFG_OFF_TIME_MS, 10);
		queue_random(450, 40);
		wait_drained();

		// last part: no idling on either side
		idle_free = 1;
		queue_random(350, 40);
		wait_drained();

		$display("covered %0d results over five register settings, incl. extremes,", results_seen);
		$display("timer cycling, invalid and diffuse echoes, and a long output hold-off");
		if (errors == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> dual_range_kalman_trigger.f
rtl/drkt_pkg.sv
rtl/dual_range_kalman_trigger.sv
verif/tb_dual_range_kalman_trigger.sv
